// ----- sv/bgc_pkg.sv -----
// ----------------------------------------------------------------------------
// Button gesture classifier package
// Shared constants, register indexes, event codes, sequencer states and the
// event request struct passed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

  // Number of buttons tracked by the classifier.
  localparam int BUTTON_COUNT = 8;
  // Width of an internal button cursor.
  localparam int BIDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  // Width of the walk counter, which must also hold BUTTON_COUNT itself.
  localparam int KCNT_W = $clog2(BUTTON_COUNT + 1);

  // Field widths.
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 16;
  localparam int BTN_W   = 3;
  localparam int KIND_W  = 3;
  localparam int CFG_W   = 16;
  localparam int CFGA_W  = 2;

  // Configuration register indexes.
  localparam logic [CFGA_W-1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [CFGA_W-1:0] REG_MULTI_GAP = 2'd1;
  localparam logic [CFGA_W-1:0] REG_LONG_TIME = 2'd2;
  localparam logic [CFGA_W-1:0] REG_PULLED_UP = 2'd3;

  // Register reset values.
  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd25;
  localparam logic [CFG_W-1:0] MULTI_GAP_RST = 16'd180;
  localparam logic [CFG_W-1:0] LONG_TIME_RST = 16'd800;

  // Input command codes.
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Saturation limit of the click counter.
  localparam logic [CNT_W-1:0] CLICK_MAX = '1;

  // Event codes.
  typedef enum logic [KIND_W-1:0] {
    EV_RELEASE     = 3'd0,
    EV_PRESS       = 3'd1,
    EV_LONG_START  = 3'd2,
    EV_LONG_CLICK  = 3'd3,
    EV_SINGLE      = 3'd4,
    EV_MULTI       = 3'd5
  } kind_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEB_SUB,
    ST_DEB_CMP,
    ST_WALK,
    ST_PERIOD,
    ST_CMP_LONG,
    ST_CMP_GAP,
    ST_EV_CHANGE,
    ST_EV_GESTURE,
    ST_FINISH
  } state_e;

  // Request from the sequencer to the output stage.
  typedef struct packed {
    logic              push;    // new event to hold as pending
    logic              flush;   // end of item: release pending event as last
    logic [BTN_W-1:0]  button;
    kind_e             kind;
    logic [CNT_W-1:0]  count;
  } emit_req_t;

endpackage

`default_nettype wire

// ----- sv/bgc_evq.sv -----
// ----------------------------------------------------------------------------
// Button gesture classifier output stage
// Holds one pending event until the next event or the end of the item shows
// whether it is the final one, then moves it to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_evq
  import bgc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire emit_req_t         req_i,
  output logic                   rdy_o,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // tdata fields from bit 0: event_button[2:0], tally[18:3], zero fill
  output logic [23:0]            m_axis_tdata,
  // tuser fields from bit 0: event_kind[2:0]
  output logic [KIND_W-1:0]      m_axis_tuser,
  output logic                   m_axis_tlast
);

  logic              pend_vld_q;
  logic [BTN_W-1:0]  pend_btn_q;
  kind_e             pend_kind_q;
  logic [CNT_W-1:0]  pend_cnt_q;

  logic              out_vld_q;
  logic [BTN_W-1:0]  out_btn_q;
  kind_e             out_kind_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic              out_last_q;

  logic load_ok;
  logic load;

  // The output register is free when empty or being drained this cycle.
  assign load_ok = !out_vld_q || m_axis_tready;
  assign rdy_o   = !pend_vld_q || load_ok;
  assign load    = pend_vld_q && (req_i.push || req_i.flush) && load_ok;

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (req_i.push && rdy_o) begin
        pend_vld_q <= 1'b1;
      end else if (req_i.flush && rdy_o) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_btn_q  <= pend_btn_q;
      out_kind_q <= pend_kind_q;
      out_cnt_q  <= pend_cnt_q;
      out_last_q <= req_i.flush;
    end
    if (req_i.push && rdy_o) begin
      pend_btn_q  <= req_i.button;
      pend_kind_q <= req_i.kind;
      pend_cnt_q  <= req_i.count;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_cnt_q, out_btn_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- sv/button_gesture_classifier.sv -----
// ----------------------------------------------------------------------------
// Button gesture classifier
// Debounces pin edges and walks all busy buttons to report press, release,
// long-press, long click, single click and multi click events.
// ----------------------------------------------------------------------------
// One item is taken at a time; s_axis_tready stays low until its last event
// has been handed to the output register. A tick or accepted edge is taken
// in idle, then the walk visits every button in turn; a busy button also goes
// through a period subtract, two compares on the shared 32-bit subtractor and
// two event steps. The walk ends with a check for its end and a close step,
// and an edge first passes a debounce subtract and compare. An edge that the
// debounce check drops returns to idle after its compare.
// Events come out with tlast marking the final one of an item; an item that
// produces no event gives no transfer. Stalls on the output side hold the
// walk only when an event has to be moved and the output register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module button_gesture_classifier
  import bgc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration write port
  input  wire logic              cfg_we_i,
  input  wire logic [CFGA_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  // Input stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata fields from bit 0: button_index[2:0], pin_level[3], now_time[35:4], zero fill
  input  wire logic [39:0]       s_axis_tdata,
  // tuser fields from bit 0: command[0]
  input  wire logic              s_axis_tuser,
  // Event stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // tdata fields from bit 0: event_button[2:0], tally[18:3], zero fill
  output logic [23:0]            m_axis_tdata,
  // tuser fields from bit 0: event_kind[2:0]
  output logic [KIND_W-1:0]      m_axis_tuser,
  output logic                   m_axis_tlast
);

  // Configuration registers
  logic [CFG_W-1:0] debounce_q;
  logic [CFG_W-1:0] gap_q;
  logic [CFG_W-1:0] long_q;
  logic             pulled_up_q;

  // Per-button state
  logic [BUTTON_COUNT-1:0] pnow_q;
  logic [BUTTON_COUNT-1:0] pstab_q;
  logic [BUTTON_COUNT-1:0] busy_q;
  logic [TIME_W-1:0]       edge_time_q    [BUTTON_COUNT];
  logic [TIME_W-1:0]       stable_since_q [BUTTON_COUNT];
  logic [CNT_W-1:0]        clicks_q       [BUTTON_COUNT];

  // Sequencer
  state_e            state_q, state_d;
  logic              lvl_q;
  logic [TIME_W-1:0] now_q;
  logic [BIDX_W-1:0] cur_q, cur_d;
  logic [KCNT_W-1:0] k_q, k_d;
  logic [TIME_W-1:0] diff_q, diff_d;
  logic              ge_long_q, ge_long_d;
  logic              ge_gap_q, ge_gap_d;

  // Shared subtractor
  logic [TIME_W-1:0] alu_a, alu_b;
  logic [TIME_W:0]   alu_res;
  logic              alu_borrow;

  // Strobes from the sequencer
  logic      accept;
  logic      apply_edge;
  logic      inc_click;
  logic      clr_click;
  logic      clr_busy;
  logic      commit_stable;
  emit_req_t req;
  logic      evq_rdy;

  // Fields of the current button
  logic              cur_now;
  logic              cur_stab;
  logic [CNT_W-1:0]  cur_clicks;
  logic              changed;
  logic [BIDX_W-1:0] cur_next;
  logic [BTN_W-1:0]  in_idx;

  assign in_idx     = s_axis_tdata[2:0];
  assign cur_now    = pnow_q[cur_q];
  assign cur_stab   = pstab_q[cur_q];
  assign cur_clicks = clicks_q[cur_q];
  assign changed    = cur_now != cur_stab;
  assign cur_next   = (cur_q == BIDX_W'(BUTTON_COUNT - 1)) ? '0 : cur_q + 1'b1;
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Operand selection for the shared subtractor.
  always_comb begin
    unique case (state_q)
      ST_DEB_CMP:  begin
        alu_a = diff_q;
        alu_b = {{(TIME_W-CFG_W){1'b0}}, debounce_q};
      end
      ST_CMP_LONG: begin
        alu_a = diff_q;
        alu_b = {{(TIME_W-CFG_W){1'b0}}, long_q};
      end
      ST_CMP_GAP:  begin
        alu_a = diff_q;
        alu_b = {{(TIME_W-CFG_W){1'b0}}, gap_q};
      end
      default:     begin
        alu_a = now_q;
        alu_b = stable_since_q[cur_q];
      end
    endcase
  end

  assign alu_res    = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_res[TIME_W];

  // Next state and strobes.
  always_comb begin
    state_d       = state_q;
    cur_d         = cur_q;
    k_d           = k_q;
    diff_d        = diff_q;
    ge_long_d     = ge_long_q;
    ge_gap_d      = ge_gap_q;
    apply_edge    = 1'b0;
    inc_click     = 1'b0;
    clr_click     = 1'b0;
    clr_busy      = 1'b0;
    commit_stable = 1'b0;
    req.push      = 1'b0;
    req.flush     = 1'b0;
    req.button    = BTN_W'(cur_q);
    req.kind      = EV_RELEASE;
    req.count     = cur_clicks;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          k_d = '0;
          if (s_axis_tuser == CMD_TICK) begin
            cur_d   = '0;
            state_d = ST_WALK;
          end else if (32'(in_idx) >= BUTTON_COUNT) begin
            state_d = ST_IDLE;
          end else begin
            cur_d   = BIDX_W'(in_idx);
            state_d = ST_DEB_SUB;
          end
        end
      end

      ST_DEB_SUB: begin
        diff_d  = alu_res[TIME_W-1:0];
        state_d = ST_DEB_CMP;
      end

      ST_DEB_CMP: begin
        // An edge too soon after the last judged change is dropped.
        if (alu_borrow) begin
          state_d = ST_IDLE;
        end else begin
          apply_edge = 1'b1;
          state_d    = ST_WALK;
        end
      end

      ST_WALK: begin
        if (k_q == KCNT_W'(BUTTON_COUNT)) begin
          state_d = ST_FINISH;
        end else if (busy_q[cur_q]) begin
          state_d = ST_PERIOD;
        end else begin
          cur_d = cur_next;
          k_d   = k_q + 1'b1;
        end
      end

      ST_PERIOD: begin
        diff_d  = alu_res[TIME_W-1:0];
        state_d = ST_CMP_LONG;
      end

      ST_CMP_LONG: begin
        ge_long_d = !alu_borrow;
        state_d   = ST_CMP_GAP;
      end

      ST_CMP_GAP: begin
        ge_gap_d = !alu_borrow;
        state_d  = ST_EV_CHANGE;
      end

      ST_EV_CHANGE: begin
        // Press or release report, then count a completed click.
        req.push = changed;
        req.kind = cur_now ? EV_PRESS : EV_RELEASE;
        if (!changed || evq_rdy) begin
          inc_click = !cur_now && cur_stab && (cur_clicks != CLICK_MAX);
          state_d   = ST_EV_GESTURE;
        end
      end

      ST_EV_GESTURE: begin
        // Long-press and click classification, in priority order.
        priority if (ge_long_q) begin
          if (cur_now && cur_stab) begin
            req.push = 1'b1;
            req.kind = EV_LONG_START;
          end else if (cur_clicks == CNT_W'(1)) begin
            req.push = 1'b1;
            req.kind = EV_LONG_CLICK;
          end
        end else if (ge_gap_q) begin
          if (cur_clicks != '0) begin
            req.push = 1'b1;
            req.kind = (cur_clicks == CNT_W'(1)) ? EV_SINGLE : EV_MULTI;
          end
        end
        if (!req.push || evq_rdy) begin
          clr_click     = req.push;
          clr_busy      = ge_long_q ? req.push : (ge_gap_q && !cur_now);
          commit_stable = changed;
          cur_d         = cur_next;
          k_d           = k_q + 1'b1;
          state_d       = ST_WALK;
        end
      end

      ST_FINISH: begin
        req.flush = 1'b1;
        if (evq_rdy) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      k_q     <= k_d;
    end
  end

  // Item fields and arithmetic results.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lvl_q <= s_axis_tdata[3];
      now_q <= s_axis_tdata[35:4];
    end
    diff_q    <= diff_d;
    ge_long_q <= ge_long_d;
    ge_gap_q  <= ge_gap_d;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DEBOUNCE_RST;
      gap_q       <= MULTI_GAP_RST;
      long_q      <= LONG_TIME_RST;
      pulled_up_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE:  debounce_q  <= cfg_data_i;
        REG_MULTI_GAP: gap_q       <= cfg_data_i;
        REG_LONG_TIME: long_q      <= cfg_data_i;
        REG_PULLED_UP: pulled_up_q <= cfg_data_i[0];
        default:       debounce_q  <= debounce_q;
      endcase
    end
  end

  // Per-button state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pnow_q  <= '0;
      pstab_q <= '0;
      busy_q  <= '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        edge_time_q[i]    <= '0;
        stable_since_q[i] <= '0;
        clicks_q[i]       <= '0;
      end
    end else begin
      if (apply_edge) begin
        pnow_q[cur_q]      <= lvl_q ^ pulled_up_q;
        edge_time_q[cur_q] <= now_q;
        busy_q[cur_q]      <= 1'b1;
      end
      if (inc_click) begin
        clicks_q[cur_q] <= cur_clicks + 1'b1;
      end else if (clr_click) begin
        clicks_q[cur_q] <= '0;
      end
      if (clr_busy) begin
        busy_q[cur_q] <= 1'b0;
      end
      if (commit_stable) begin
        pstab_q[cur_q]        <= cur_now;
        stable_since_q[cur_q] <= edge_time_q[cur_q];
      end
    end
  end

  // Output stage.
  bgc_evq u_evq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .rdy_o         (evq_rdy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // A button that is no longer judged has its level fully settled.
  a_idle_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q | ~(pnow_q ^ pstab_q)) == {BUTTON_COUNT{1'b1}})
    else $error("idle button with unjudged level change");

  // An accepted item always drops the input ready after its transfer.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // The walk finishes only after visiting every button.
  a_walk_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && state_d == ST_FINISH) |-> (k_q == KCNT_W'(BUTTON_COUNT)))
    else $error("walk ended early");

  // Closing an item returns the sequencer to idle on the next cycle.
  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && evq_rdy) |=> (state_q == ST_IDLE))
    else $error("item not closed after flush");

  // A tick starts its walk at button zero.
  a_tick_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == CMD_TICK) |=> (cur_q == '0 && state_q == ST_WALK))
    else $error("tick walk did not start at button zero");
`endif

endmodule

`default_nettype wire
